@@ hdl/tdc_pkg.sv @@
// shared types and constants for the tag dedup cache
package tdc_pkg;

   localparam int CACHE_ENTRIES_DEF = 16;

   localparam logic signed [7:0] THRESHOLD_RESET = -8'sd70;
   localparam logic [15:0]       WINDOW_RESET    = 16'd3000;
   localparam logic [7:0]        HITS_MAX        = 8'd255;
   localparam logic [7:0]        HITS_FIRST      = 8'd1;

   // fixed-point reciprocal of ten, scaled by 2^16
   localparam logic [12:0] RECIP_TENTH = 13'd6554;
   localparam int          RECIP_SHIFT = 16;

   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_SWEEP  = 1'b1;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_WINDOW    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MIX,
      ST_SCALE,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [63:0]        id_low;
      logic [31:0]        id_high;
      logic [31:0]        seen_time;
      logic signed [7:0]  signal;
      logic [7:0]         hits;
   } entry_type;

endpackage

@@ hdl/tag_dedup_cache.sv @@
// tag dedup cache top level: entry memory, scan sequencer and update datapath
//
// Each beat (start high while busy is low) is taken into ST_SCAN and gets its
// single result in ST_WRITE. The scan does one entry memory read per cycle
// over the whole table and then the last compare. Match, first free slot,
// eviction candidate and sweep expiry are all decided during that scan. A
// hit then goes through ST_MIX and ST_SCALE for RSSI smoothing arithmetic and
// a miss through ST_MIX only; a sweep skips them. The last state, ST_WRITE,
// writes back a report's entry and presents the result. rsp_valid is high
// for exactly one cycle and cannot be stalled; busy is low again in the
// cycle after it. Entry valid bits sit in flip-flops and clear at reset, so
// no clearing pass is needed. Configuration is written through the APB
// port while busy is low: the user must keep to this, since the block
// itself does not enforce it.
module tag_dedup_cache
   import tdc_pkg::*;
#(
   parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [63:0]        req_epc_low,
   input  logic [31:0]        req_epc_high,
   input  logic signed [7:0]  req_rssi,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   output logic               rsp_is_duplicate,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int IDX_W = $clog2(CACHE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

   state_type state_ff, state_in;

   entry_type entry_mem [CACHE_ENTRIES];
   entry_type rd_data_ff;
   entry_type wr_data;
   logic [IDX_W-1:0] wr_idx;
   logic rd_en, wr_en;

   logic [CACHE_ENTRIES-1:0] valid_ff;

   logic signed [7:0] thr_ff;
   logic [15:0]       window_ff;

   logic               op_ff;
   logic [63:0]        lo_ff;
   logic [31:0]        hi_ff;
   logic signed [7:0]  rssi_ff;
   logic [31:0]        now_ff;

   logic [IDX_W-1:0] rd_idx_ff, cmp_idx_ff;
   logic             rd_done_ff, cmp_valid_ff;

   logic             hit_found_ff, empty_found_ff;
   logic [IDX_W-1:0] hit_idx_ff, empty_idx_ff, victim_idx_ff;
   logic signed [7:0] hit_sig_ff;
   logic [31:0]      hit_time_ff;
   logic [7:0]       hit_hits_ff;
   logic [7:0]       victim_hits_ff;
   logic [31:0]      victim_time_ff;

   logic signed [11:0] num_ff;
   logic signed [7:0]  smooth_ff;

   logic accept, scan_last, cmp_entry_valid, id_match, stale, take_victim;
   logic [31:0] cmp_age;

   logic signed [8:0]  diff;
   logic signed [11:0] sig_x, raw_x, num_in;
   logic [10:0] mag;
   logic [23:0] prod;
   logic [7:0]  quo;

   logic under_thr, young, dup;
   logic [31:0] hit_age;
   logic [7:0] hits_next;

   logic cfg_write;

   // configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (paddr[2])
         CSR_THRESHOLD: prdata = {{24{thr_ff[7]}}, thr_ff};
         CSR_WINDOW:    prdata = {16'd0, window_ff};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RESET;
         window_ff <= WINDOW_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == CSR_THRESHOLD) thr_ff <= $signed(pwdata[7:0]);
         else window_ff <= pwdata[15:0];
      end
   end

   // control
   assign accept    = start && !busy;
   assign scan_last = cmp_valid_ff && (cmp_idx_ff == LAST_IDX);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SCAN;
         ST_SCAN:  if (scan_last) state_in = (op_ff == OP_SWEEP) ? ST_WRITE : ST_MIX;
         ST_MIX:   state_in = hit_found_ff ? ST_SCALE : ST_WRITE;
         ST_SCALE: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rd_en     = (state_ff == ST_SCAN) && !rd_done_ff;
      wr_en     = (state_ff == ST_WRITE) && (op_ff == OP_REPORT);
      rsp_valid = (state_ff == ST_WRITE);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= entry_mem[rd_idx_ff];
      if (wr_en) entry_mem[wr_idx] <= wr_data;
   end

   // scan compare
   assign cmp_entry_valid = valid_ff[cmp_idx_ff];
   assign id_match = (rd_data_ff.id_low == lo_ff) && (rd_data_ff.id_high == hi_ff);
   assign cmp_age  = now_ff - rd_data_ff.seen_time;
   assign stale    = cmp_age > {16'd0, window_ff};
   assign take_victim = (cmp_idx_ff == '0)
                     || (rd_data_ff.hits < victim_hits_ff)
                     || ((rd_data_ff.hits == victim_hits_ff)
                         && (rd_data_ff.seen_time < victim_time_ff));

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         lo_ff   <= req_epc_low;
         hi_ff   <= req_epc_high;
         rssi_ff <= req_rssi;
         now_ff  <= req_now_ms;
      end
      if (state_ff == ST_SCAN && cmp_valid_ff) begin
         if (cmp_entry_valid && id_match && !hit_found_ff) begin
            hit_idx_ff  <= cmp_idx_ff;
            hit_sig_ff  <= rd_data_ff.signal;
            hit_time_ff <= rd_data_ff.seen_time;
            hit_hits_ff <= rd_data_ff.hits;
         end
         if (!cmp_entry_valid && !empty_found_ff) empty_idx_ff <= cmp_idx_ff;
         if (take_victim) begin
            victim_idx_ff  <= cmp_idx_ff;
            victim_hits_ff <= rd_data_ff.hits;
            victim_time_ff <= rd_data_ff.seen_time;
         end
      end
      if (state_ff == ST_MIX)   num_ff    <= num_in;
      if (state_ff == ST_SCALE) smooth_ff <= (num_ff < 0) ? 8'(8'd0 - quo) : quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff      <= '0;
         cmp_idx_ff     <= '0;
         rd_done_ff     <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         hit_found_ff   <= 1'b0;
         empty_found_ff <= 1'b0;
         valid_ff       <= '0;
      end else begin
         if (accept) begin
            rd_idx_ff      <= '0;
            rd_done_ff     <= 1'b0;
            cmp_valid_ff   <= 1'b0;
            hit_found_ff   <= 1'b0;
            empty_found_ff <= 1'b0;
         end else if (state_ff == ST_SCAN) begin
            cmp_valid_ff <= rd_en;
            cmp_idx_ff   <= rd_idx_ff;
            if (rd_en) begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
               if (rd_idx_ff == LAST_IDX) rd_done_ff <= 1'b1;
            end
            if (cmp_valid_ff) begin
               if (op_ff == OP_REPORT) begin
                  if (cmp_entry_valid && id_match) hit_found_ff <= 1'b1;
                  if (!cmp_entry_valid) empty_found_ff <= 1'b1;
               end else if (cmp_entry_valid && stale) begin
                  valid_ff[cmp_idx_ff] <= 1'b0;
               end
            end
         end else if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // rssi smoothing: weighted sum, then divide by ten toward zero
   assign sig_x = {{4{hit_sig_ff[7]}}, hit_sig_ff};
   assign raw_x = {{4{rssi_ff[7]}}, rssi_ff};
   assign diff  = {rssi_ff[7], rssi_ff} - {hit_sig_ff[7], hit_sig_ff};
   assign num_in = (diff > -9'sd3 && diff < 9'sd3)
                 ? (sig_x * 12'sd9) + raw_x
                 : (sig_x * 12'sd6) + (raw_x * 12'sd4);

   assign mag  = (num_ff < 0) ? 11'(12'd0 - num_ff) : num_ff[10:0];
   assign prod = mag * RECIP_TENTH;
   assign quo  = prod[RECIP_SHIFT+7:RECIP_SHIFT];

   // write back and result
   assign hit_age   = now_ff - hit_time_ff;
   assign under_thr = smooth_ff < thr_ff;
   assign young     = hit_age < {16'd0, window_ff};
   assign dup       = under_thr || young;
   assign hits_next = (hit_hits_ff == HITS_MAX) ? HITS_MAX : hit_hits_ff + 8'd1;

   always_comb begin
      wr_data.id_low  = lo_ff;
      wr_data.id_high = hi_ff;
      if (hit_found_ff) begin
         wr_idx            = hit_idx_ff;
         wr_data.seen_time = (under_thr || !young) ? now_ff : hit_time_ff;
         wr_data.signal    = under_thr ? hit_sig_ff : smooth_ff;
         wr_data.hits      = hits_next;
      end else begin
         wr_idx            = empty_found_ff ? empty_idx_ff : victim_idx_ff;
         wr_data.seen_time = now_ff;
         wr_data.signal    = rssi_ff;
         wr_data.hits      = HITS_FIRST;
      end
   end

   assign rsp_is_duplicate = rsp_valid && (op_ff == OP_REPORT) && hit_found_ff && dup;

endmodule
